FILE: design/blm_pkg.sv
// Package for the line minimizer: status codes, phase codes, fixed-point helpers.
package blm_pkg;

   localparam int unsigned FractionBitsDefault = 16;
   localparam int unsigned TolBits = 16;

   localparam logic [1:0] STATUS_EVAL  = 2'd0;
   localparam logic [1:0] STATUS_CONV  = 2'd1;
   localparam logic [1:0] STATUS_LIMIT = 2'd2;
   localparam logic [1:0] STATUS_BAD   = 2'd3;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_FIRST = 2'd1;
   localparam logic [1:0] PHASE_TRIAL = 2'd2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_VALUE = 1'b1;

   localparam logic [1:0] CSR_TOLERANCE = 2'd0;
   localparam logic [1:0] CSR_ITER_LIMIT = 2'd1;

   // Datapath operations, issued one per cycle by the controller.
   localparam logic [4:0] OP_NOP = 5'd0, OP_START = 5'd1, OP_FIRST = 5'd2,
      OP_ABSORB = 5'd3, OP_LIMIT = 5'd4, OP_TOL = 5'd5, OP_CONV = 5'd6,
      OP_PSEL = 5'd7, OP_R = 5'd8, OP_Q = 5'd9, OP_P1 = 5'd10, OP_P2 = 5'd11,
      OP_Q2 = 5'd12, OP_HQE = 5'd13, OP_QA = 5'd14, OP_QB = 5'd15,
      OP_ACC = 5'd16, OP_DIVGO = 5'd17, OP_DIVEND = 5'd18, OP_GOLD1 = 5'd19,
      OP_GOLD2 = 5'd20, OP_FINAL = 5'd21;

   // Saturate a 66-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      begin
         hi = 66'sd2147483647;
         lo = -66'sd2147483648;
         if (v > hi) sat32 = 32'sh7fffffff;
         else if (v < lo) sat32 = 32'sh80000000;
         else sat32 = v[31:0];
      end
   endfunction

endpackage

FILE: design/blm_datapath.sv
// Datapath of the line minimizer: search state, shared multiplier, serial divider.
module blm_datapath #(
   parameter int unsigned FRACTION_BITS = blm_pkg::FractionBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [4:0]          op,
   input  logic signed [31:0]  in_low,
   input  logic signed [31:0]  in_mid,
   input  logic signed [31:0]  in_high,
   input  logic signed [31:0]  in_value,
   input  logic [15:0]         tolerance,
   input  logic [7:0]          iter_limit,
   output logic                flag,
   output logic                div_busy,
   output logic signed [31:0]  best_point,
   output logic signed [31:0]  best_value,
   output logic signed [31:0]  trial_point
);
   import blm_pkg::*;

   localparam logic signed [31:0] Gold = 32'((((64'd3819660) << FRACTION_BITS)
                                              + 64'd5000000) / 64'd10000000);
   // Dividend is |p| shifted up by the fraction bits.
   localparam int unsigned DivBits = 32 + FRACTION_BITS;
   localparam int unsigned RemBits = DivBits + 1;

   logic signed [31:0] a_ff, b_ff, x_ff, w_ff, v_ff, fx_ff, fw_ff, fv_ff;
   logic signed [31:0] d_ff, e_ff, u_ff;
   logic [7:0]         iter_ff;
   logic signed [31:0] xm_ff, tol1_ff, tol2_ff;
   logic signed [31:0] r_ff, q_ff, p_ff, t_ff, etemp_ff;
   logic signed [32:0] hqe_ff;
   logic signed [31:0] qa_ff, qb_ff;
   logic               flag_ff;

   // Serial divider state: magnitude restoring division.
   logic [DivBits-1:0] dnum_ff;
   logic [31:0]        dden_ff;
   logic [RemBits-1:0] drem_ff;
   logic [5:0]         dcnt_ff;
   logic               dneg_ff;
   logic               dbusy_ff;

   // Shared multiplier with floor shift and saturation.
   logic signed [31:0] ma, mb;
   logic signed [63:0] mprod;
   logic signed [31:0] mres;

   function automatic logic abss_ge(input logic signed [31:0] v, input logic signed [31:0] t);
      logic signed [32:0] m;
      begin
         m = v[31] ? -33'(v) : 33'(v);
         if (m > 33'sd2147483647) m = 33'sd2147483647;
         abss_ge = (m >= 33'(t));
      end
   endfunction

   always_comb begin
      ma = 32'sd0;
      mb = 32'sd0;
      unique case (op)
         OP_R:     begin ma = sat32(66'(x_ff) - 66'(w_ff)); mb = sat32(66'(fx_ff) - 66'(fv_ff)); end
         OP_Q:     begin ma = sat32(66'(x_ff) - 66'(v_ff)); mb = sat32(66'(fx_ff) - 66'(fw_ff)); end
         OP_P1:    begin ma = sat32(66'(x_ff) - 66'(v_ff)); mb = q_ff; end
         OP_P2:    begin ma = sat32(66'(x_ff) - 66'(w_ff)); mb = r_ff; end
         OP_HQE:   begin ma = q_ff; mb = etemp_ff; end
         OP_QA:    begin ma = q_ff; mb = sat32(66'(a_ff) - 66'(x_ff)); end
         OP_QB:    begin ma = q_ff; mb = sat32(66'(b_ff) - 66'(x_ff)); end
         OP_GOLD2: begin ma = Gold; mb = e_ff; end
         default:  begin ma = 32'sd0; mb = 32'sd0; end
      endcase
      mprod = 64'(ma) * 64'(mb);
      mres = sat32(66'(mprod >>> FRACTION_BITS));
   end

   logic signed [31:0] tol1_c, abs_x, neg_tol1;
   logic [47:0]        tolprod;
   logic signed [33:0] dist_c, lim_c;
   logic signed [31:0] abs_p, abs_e, u_c, dsel;
   logic [RemBits-1:0] dtrial;
   logic signed [31:0] dq_c;

   always_comb begin
      abs_x = sat32(x_ff[31] ? -66'(x_ff) : 66'(x_ff));
      tolprod = 48'(tolerance) * 48'(unsigned'(abs_x));
      tol1_c = sat32(66'(tolprod >> TolBits) + 66'sd1);
      neg_tol1 = sat32(-66'(tol1_ff));
      dist_c = 34'(x_ff) - 34'(xm_ff);
      if (dist_c < 0) dist_c = -dist_c;
      lim_c = 34'(tol2_ff) - ((34'(b_ff) - 34'(a_ff)) >>> 1);
      abs_p = sat32(p_ff[31] ? -66'(p_ff) : 66'(p_ff));
      abs_e = sat32(e_ff[31] ? -66'(e_ff) : 66'(e_ff));
      dtrial = {drem_ff[DivBits-1:0], dnum_ff[DivBits-1]} - RemBits'(dden_ff);
      // Apply the sign to the quotient magnitude, then saturate to 32 bits.
      dq_c = dneg_ff ? sat32(-$signed(66'(dnum_ff))) : sat32(66'(dnum_ff));
      dsel = (abss_ge(d_ff, tol1_ff)) ? d_ff : (d_ff > 0 ? tol1_ff : neg_tol1);
      u_c = sat32(66'(x_ff) + 66'(dsel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; x_ff <= '0; w_ff <= '0; v_ff <= '0;
         fx_ff <= '0; fw_ff <= '0; fv_ff <= '0; d_ff <= '0; e_ff <= '0; u_ff <= '0;
         iter_ff <= '0; flag_ff <= 1'b0; dbusy_ff <= 1'b0; dcnt_ff <= '0;
      end else begin
         unique case (op)
            OP_START: begin
               a_ff <= (in_low < in_high) ? in_low : in_high;
               b_ff <= (in_low > in_high) ? in_low : in_high;
               x_ff <= in_mid; w_ff <= in_mid; v_ff <= in_mid;
               fx_ff <= '0; fw_ff <= '0; fv_ff <= '0;
               d_ff <= '0; e_ff <= '0; u_ff <= in_mid; iter_ff <= '0;
            end
            OP_FIRST: begin
               fx_ff <= in_value; fw_ff <= in_value; fv_ff <= in_value;
            end
            OP_ABSORB: begin
               if (in_value <= fx_ff) begin
                  if (u_ff >= x_ff) a_ff <= x_ff; else b_ff <= x_ff;
                  v_ff <= w_ff; w_ff <= x_ff; x_ff <= u_ff;
                  fv_ff <= fw_ff; fw_ff <= fx_ff; fx_ff <= in_value;
               end else begin
                  if (u_ff < x_ff) a_ff <= u_ff; else b_ff <= u_ff;
                  if (in_value <= fw_ff || w_ff == x_ff) begin
                     v_ff <= w_ff; w_ff <= u_ff; fv_ff <= fw_ff; fw_ff <= in_value;
                  end else if (in_value <= fv_ff || v_ff == x_ff || v_ff == w_ff) begin
                     v_ff <= u_ff; fv_ff <= in_value;
                  end
               end
            end
            OP_LIMIT: begin
               flag_ff <= (iter_ff >= iter_limit);
               if (iter_ff < iter_limit) iter_ff <= iter_ff + 8'd1;
            end
            OP_TOL: begin
               xm_ff <= 32'((34'(a_ff) + 34'(b_ff)) >>> 1);
               tol1_ff <= tol1_c;
               tol2_ff <= sat32(66'(tol1_c) * 66'sd2);
            end
            OP_CONV: flag_ff <= (dist_c <= lim_c);
            OP_PSEL: flag_ff <= (abs_e > tol1_ff);
            OP_R:  r_ff <= mres;
            OP_Q:  q_ff <= mres;
            OP_P1: t_ff <= mres;
            OP_P2: p_ff <= sat32(66'(t_ff) - 66'(mres));
            OP_Q2: begin
               logic signed [31:0] q2;
               q2 = sat32(66'(sat32(66'(q_ff) - 66'(r_ff))) * 66'sd2);
               if (q2 > 0) p_ff <= sat32(-66'(p_ff));
               q_ff <= sat32(q2[31] ? -66'(q2) : 66'(q2));
               etemp_ff <= e_ff;
               e_ff <= d_ff;
            end
            OP_HQE: hqe_ff <= 33'(sat32(mres[31] ? -66'(mres) : 66'(mres))) >>> 1;
            OP_QA: qa_ff <= mres;
            OP_QB: qb_ff <= mres;
            OP_ACC: flag_ff <= (33'(abs_p) >= hqe_ff) || (p_ff <= qa_ff) || (p_ff >= qb_ff);
            OP_DIVGO: begin
               dnum_ff <= DivBits'(unsigned'(p_ff[31] ? -33'(p_ff) : 33'(p_ff))) << FRACTION_BITS;
               dden_ff <= 32'(q_ff);
               dneg_ff <= p_ff[31];
               drem_ff <= '0;
               dcnt_ff <= 6'(DivBits);
               dbusy_ff <= 1'b1;
            end
            OP_DIVEND: begin
               logic signed [31:0] dq;
               logic signed [31:0] uu;
               dq = dq_c;
               uu = sat32(66'(x_ff) + 66'(dq));
               if ((34'(uu) - 34'(a_ff) < 34'(tol2_ff)) || (34'(b_ff) - 34'(uu) < 34'(tol2_ff)))
                  d_ff <= (xm_ff > x_ff) ? tol1_ff : neg_tol1;
               else
                  d_ff <= dq;
            end
            OP_GOLD1: e_ff <= (x_ff >= xm_ff) ? sat32(66'(a_ff) - 66'(x_ff))
                                              : sat32(66'(b_ff) - 66'(x_ff));
            OP_GOLD2: d_ff <= mres;
            OP_FINAL: u_ff <= u_c;
            default: ;
         endcase
         if (dbusy_ff) begin
            // One quotient bit per cycle, shifting into dnum.
            if (!dtrial[DivBits]) drem_ff <= dtrial;
            else drem_ff <= {drem_ff[DivBits-1:0], dnum_ff[DivBits-1]};
            dnum_ff <= {dnum_ff[DivBits-2:0], ~dtrial[DivBits]};
            dcnt_ff <= dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd1) dbusy_ff <= 1'b0;
         end
      end
   end

   assign flag = flag_ff;
   assign div_busy = dbusy_ff;
   assign best_point = x_ff;
   assign best_value = fx_ff;
   assign trial_point = u_ff;
endmodule

FILE: design/blm_control.sv
// Controller of the line minimizer: sequences datapath operations per transfer.
module blm_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_accept,
   input  logic        req_command,
   input  logic        flag,
   input  logic        div_busy,
   input  logic        rsp_free,
   output logic [4:0]  op,
   output logic        busy,
   output logic        rsp_load,
   output logic [1:0]  rsp_status
);
   import blm_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0, S_LIMIT = 5'd1, S_LIMCHK = 5'd2, S_TOL = 5'd3,
      S_CONV = 5'd4, S_CONVCHK = 5'd5, S_PSEL = 5'd6, S_PSELCHK = 5'd7, S_R = 5'd8,
      S_Q = 5'd9, S_P1 = 5'd10, S_P2 = 5'd11, S_Q2 = 5'd12, S_HQE = 5'd13, S_QA = 5'd14,
      S_QB = 5'd15, S_ACC = 5'd16, S_ACCCHK = 5'd17, S_DIVGO = 5'd18, S_DIVW = 5'd19,
      S_DIVEND = 5'd20, S_GOLD1 = 5'd21, S_GOLD2 = 5'd22, S_FINAL = 5'd23,
      S_OUT = 5'd24, S_ABSORB = 5'd25;

   logic [4:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] st_ff, st_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      st_in = st_ff;
      op = OP_NOP;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_accept) begin
            if (req_command == CMD_START) begin
               op = OP_START; phase_in = PHASE_FIRST; st_in = STATUS_EVAL; state_in = S_OUT;
            end else if (phase_ff == PHASE_FIRST) begin
               op = OP_FIRST; state_in = S_LIMIT;
            end else if (phase_ff == PHASE_TRIAL) begin
               op = OP_ABSORB; state_in = S_LIMIT;
            end else begin
               st_in = STATUS_BAD; state_in = S_OUT;
            end
         end
         S_LIMIT:  begin op = OP_LIMIT; state_in = S_LIMCHK; end
         S_LIMCHK: if (flag) begin
            st_in = STATUS_LIMIT; phase_in = PHASE_IDLE; state_in = S_OUT;
         end else state_in = S_TOL;
         S_TOL:    begin op = OP_TOL; state_in = S_CONV; end
         S_CONV:   begin op = OP_CONV; state_in = S_CONVCHK; end
         S_CONVCHK: if (flag) begin
            st_in = STATUS_CONV; phase_in = PHASE_IDLE; state_in = S_OUT;
         end else state_in = S_PSEL;
         S_PSEL:   begin op = OP_PSEL; state_in = S_PSELCHK; end
         S_PSELCHK: state_in = flag ? S_R : S_GOLD1;
         S_R:      begin op = OP_R; state_in = S_Q; end
         S_Q:      begin op = OP_Q; state_in = S_P1; end
         S_P1:     begin op = OP_P1; state_in = S_P2; end
         S_P2:     begin op = OP_P2; state_in = S_Q2; end
         S_Q2:     begin op = OP_Q2; state_in = S_HQE; end
         S_HQE:    begin op = OP_HQE; state_in = S_QA; end
         S_QA:     begin op = OP_QA; state_in = S_QB; end
         S_QB:     begin op = OP_QB; state_in = S_ACC; end
         S_ACC:    begin op = OP_ACC; state_in = S_ACCCHK; end
         S_ACCCHK: state_in = flag ? S_GOLD1 : S_DIVGO;
         S_DIVGO:  begin op = OP_DIVGO; state_in = S_DIVW; end
         S_DIVW:   if (!div_busy) state_in = S_DIVEND;
         S_DIVEND: begin op = OP_DIVEND; state_in = S_FINAL; end
         S_GOLD1:  begin op = OP_GOLD1; state_in = S_GOLD2; end
         S_GOLD2:  begin op = OP_GOLD2; state_in = S_FINAL; end
         S_FINAL:  begin
            op = OP_FINAL; st_in = STATUS_EVAL; phase_in = PHASE_TRIAL; state_in = S_OUT;
         end
         S_OUT: if (rsp_free) begin rsp_load = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= PHASE_IDLE; st_ff <= STATUS_EVAL;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; st_ff <= st_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_status = st_ff;
endmodule

FILE: design/brent_line_minimizer_unit.sv
// Top level of the Brent line minimizer: ports, CSRs, output register.
// One item is worked on at a time. A start transfer goes straight to the output
// register. A value transfer ends when the iteration limit is hit or on
// convergence; else it takes a golden-section step, or tries a parabolic step
// and takes a golden-section step instead if that one is rejected. A parabolic
// step that is taken waits on the serial divider, which yields one quotient bit
// per cycle. The steps run through one shared 32x32 multiplier. Input is
// stalled while an item is worked on; the finished result waits in an output
// register and the block takes the next transfer on the cycle after loading it.
module brent_line_minimizer_unit #(
   parameter int unsigned FRACTION_BITS = blm_pkg::FractionBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [31:0] req_bracket_low,
   input  logic signed [31:0] req_bracket_mid,
   input  logic signed [31:0] req_bracket_high,
   input  logic signed [31:0] req_function_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_request_point,
   output logic signed [31:0] rsp_min_point,
   output logic signed [31:0] rsp_min_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import blm_pkg::*;

   logic [15:0] tol_ff;
   logic [7:0]  lim_ff;
   logic        busy, flag, div_busy, rsp_load, req_accept;
   logic [4:0]  op;
   logic [1:0]  st;
   logic signed [31:0] bp, bv, tp;
   logic        rv_ff;
   logic [1:0]  rs_ff;
   logic signed [31:0] rr_ff, rp_ff, rm_ff;

   assign csr_pready = 1'b1;

   // Write CSRs on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 16'd13;
         lim_ff <= 8'd100;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == CSR_TOLERANCE[0] && csr_paddr[1:0] == 2'd0)
            tol_ff <= csr_pwdata[15:0];
         else if (csr_paddr[2] == CSR_ITER_LIMIT[0] && csr_paddr[1:0] == 2'd0)
            lim_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_TOLERANCE[0]:  csr_prdata = {16'd0, tol_ff};
         default:           csr_prdata = {24'd0, lim_ff};
      endcase
   end

   // Accept only when idle; the output register holds the last result.
   assign req_stall = busy;
   assign req_accept = req_valid && !busy;

   blm_control u_ctrl (
      .clock(clock), .reset(reset), .req_accept(req_accept), .req_command(req_command),
      .flag(flag), .div_busy(div_busy), .rsp_free(!rv_ff || !rsp_stall),
      .op(op), .busy(busy), .rsp_load(rsp_load), .rsp_status(st)
   );

   blm_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock(clock), .reset(reset), .op(op),
      .in_low(req_bracket_low), .in_mid(req_bracket_mid), .in_high(req_bracket_high),
      .in_value(req_function_value), .tolerance(tol_ff), .iter_limit(lim_ff),
      .flag(flag), .div_busy(div_busy), .best_point(bp), .best_value(bv),
      .trial_point(tp)
   );

   // Output register: load a finished result, drop it once transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (rsp_load) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rs_ff <= st;
         rr_ff <= (st == STATUS_EVAL) ? tp : 32'sd0;
         rp_ff <= (st == STATUS_CONV || st == STATUS_LIMIT) ? bp : 32'sd0;
         rm_ff <= (st == STATUS_CONV || st == STATUS_LIMIT) ? bv : 32'sd0;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_request_point = rr_ff;
   assign rsp_min_point = rp_ff;
   assign rsp_min_value = rm_ff;
endmodule
